FILE: rtl/assert_macros.svh
// Assertion macros shared by the sliding-window event rate RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// A property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: %m");
// A condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed: %m");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

FILE: rtl/swer_pkg.sv
// Package for the sliding-window event rate block: field widths, register
// indexes and the control struct passed between the two stages. No dependencies.
`default_nettype none

package swer_pkg;

  // Fixed field widths.
  localparam int TOTAL_W   = 32;
  localparam int SLOT_W    = 16;
  localparam int SUM_W     = 22;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOG_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_SLOT = 1'd1;

  // Register reset values.
  localparam logic [SLOT_W-1:0] LOG_LENGTH_RESET = 16'd60;
  localparam logic [SLOT_W-1:0] START_SLOT_RESET = 16'd0;

  // Saturation limit of the reported window sum.
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Control of the request held in the tick stage.
  typedef struct packed {
    logic              valid;
    logic              log_full;
    logic [SLOT_W-1:0] slot;
  } stage_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/swer_ifs.sv
// Valid/ready channel interfaces for the input totals and the rate results.
// Depends on swer_pkg for the field widths.
`default_nettype none

interface swer_in_if import swer_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] keyboard_total;
  logic [TOTAL_W-1:0] mouse_total;

  modport source (output valid, keyboard_total, mouse_total, input ready);
  modport sink   (input valid, keyboard_total, mouse_total, output ready);
endinterface

interface swer_out_if import swer_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SUM_W-1:0]  window_sum;
  logic [SLOT_W-1:0] log_slot;
  logic              log_full;

  modport source (output valid, window_sum, log_slot, log_full, input ready);
  modport sink   (input valid, window_sum, log_slot, log_full, output ready);
endinterface

`default_nettype wire

FILE: rtl/swer_tick.sv
// Tick stage: new-event count from the two totals, window index and log slot.
// Depends on swer_pkg, swer_ifs and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module swer_tick import swer_pkg::*; #(
  parameter int WINDOW_TICKS     = 60,
  parameter int TICK_COUNT_WIDTH = 16,
  localparam int IDX_W           = $clog2(WINDOW_TICKS)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]            cfg_data,
  swer_in_if.sink                          tick_in,
  input  wire logic                        advance,
  output stage_ctl_t                       ctl,
  output logic [TICK_COUNT_WIDTH-1:0]      tick_count,
  output logic [IDX_W-1:0]                 win_idx
);

  localparam logic [TOTAL_W:0] TICK_MAX = (33'd1 << TICK_COUNT_WIDTH) - 33'd1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_TICKS - 1);

  logic               stage_valid;
  logic               log_full;
  logic [SLOT_W-1:0]  slot_index;
  logic [SLOT_W-1:0]  log_length;
  logic [TOTAL_W-1:0] prev_keyboard;
  logic [TOTAL_W-1:0] prev_mouse;

  logic                        accept;
  logic [TOTAL_W-1:0]          kb_delta;
  logic [TOTAL_W-1:0]          ms_delta;
  logic [TOTAL_W:0]            delta_sum;
  logic [TICK_COUNT_WIDTH-1:0] count_next;
  logic [IDX_W-1:0]            win_idx_next;
  logic [SLOT_W:0]             slot_plus;
  logic [SLOT_W-1:0]           slot_next;
  logic                        log_full_next;

  // The stage takes a request when it is empty or its request moves on.
  assign tick_in.ready = !stage_valid || advance;
  assign accept        = tick_in.valid && tick_in.ready;

  // New events since the last tick, saturated to the tick-count width.
  always_comb begin
    kb_delta  = tick_in.keyboard_total - prev_keyboard;
    ms_delta  = tick_in.mouse_total - prev_mouse;
    delta_sum = {1'b0, kb_delta} + {1'b0, ms_delta};
    if (delta_sum > TICK_MAX) begin
      count_next = {TICK_COUNT_WIDTH{1'b1}};
    end else begin
      count_next = delta_sum[TICK_COUNT_WIDTH-1:0];
    end
  end

  // Window index and log slot, both wrapping.
  always_comb begin
    win_idx_next  = (win_idx == IDX_LAST) ? '0 : win_idx + 1'b1;
    slot_plus     = {1'b0, slot_index} + 1'b1;
    slot_next     = (slot_plus >= {1'b0, log_length}) ? '0 : slot_plus[SLOT_W-1:0];
    log_full_next = (slot_next == (log_length - 16'd1));
  end

  // Payload of the held request.
  always_ff @(posedge clk) begin
    if (accept) begin
      tick_count <= count_next;
    end
  end

  // Control state, registers and running pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid   <= 1'b0;
      log_full      <= 1'b0;
      prev_keyboard <= '0;
      prev_mouse    <= '0;
      win_idx       <= '0;
      slot_index    <= START_SLOT_RESET;
      log_length    <= LOG_LENGTH_RESET;
    end else begin
      if (accept) begin
        stage_valid   <= 1'b1;
        log_full      <= log_full_next;
        prev_keyboard <= tick_in.keyboard_total;
        prev_mouse    <= tick_in.mouse_total;
        win_idx       <= win_idx_next;
        slot_index    <= slot_next;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      // A start slot write reloads the slot pointer.
      if (cfg_we) begin
        case (cfg_index)
          REG_LOG_LENGTH: log_length <= cfg_data;
          REG_START_SLOT: slot_index <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign ctl.valid    = stage_valid;
  assign ctl.log_full = log_full;
  assign ctl.slot     = slot_index;

  // The window index stays within the store.
  `ASSERT_NEVER(a_idx_range, clk, rst, win_idx > IDX_LAST)
  // A held request is not dropped while the window stage stalls.
  `ASSERT_PROP(a_stage_hold, clk, rst, stage_valid && !advance |=> stage_valid)
  // A start slot write lands in the slot pointer.
  `ASSERT_PROP(a_start_load, clk, rst,
               cfg_we && cfg_index == REG_START_SLOT |=> slot_index == $past(cfg_data))

endmodule

`default_nettype wire

FILE: rtl/swer_window.sv
// Window stage: window store read-modify-write, running total and result register.
// Depends on swer_pkg, swer_ifs and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module swer_window import swer_pkg::*; #(
  parameter int WINDOW_TICKS     = 60,
  parameter int TICK_COUNT_WIDTH = 16,
  localparam int IDX_W           = $clog2(WINDOW_TICKS)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  stage_ctl_t                       ctl,
  input  wire logic [TICK_COUNT_WIDTH-1:0] tick_count,
  input  wire logic [IDX_W-1:0]            win_idx,
  output logic                             advance,
  swer_out_if.source                       rate_out
);

  localparam int RT_W  = TICK_COUNT_WIDTH + IDX_W;
  localparam int CMP_W = (RT_W > SUM_W) ? RT_W : SUM_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_TICKS - 1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  // Window store: one tick count per slot, valid bits stand for the reset clear.
  logic [TICK_COUNT_WIDTH-1:0] counts [WINDOW_TICKS];
  logic [WINDOW_TICKS-1:0]     filled;

  logic [TICK_COUNT_WIDTH-1:0] pf_data;
  logic                        pf_filled;
  logic [IDX_W-1:0]            pf_idx;
  logic [RT_W-1:0]             running_total;
  logic                        out_valid;
  logic [SUM_W-1:0]            window_sum;
  logic [SLOT_W-1:0]           log_slot;
  logic                        log_full;

  logic [IDX_W-1:0]            pf_addr;
  logic [TICK_COUNT_WIDTH-1:0] old_count;
  logic [RT_W-1:0]             total_next;
  logic [CMP_W-1:0]            total_ext;
  logic [SUM_W-1:0]            sum_next;

  // A request moves into the result register when that register is free or its result is taken.
  assign advance = ctl.valid && (!out_valid || rate_out.ready);

  // The next request uses the following slot; it is read one request ahead.
  assign pf_addr   = (win_idx == IDX_LAST) ? '0 : win_idx + 1'b1;
  assign old_count = pf_filled ? pf_data : '0;

  // Add the new count, drop the count that leaves the window, saturate.
  always_comb begin
    total_next = running_total + RT_W'(tick_count) - RT_W'(old_count);
    total_ext  = CMP_W'(total_next);
    if (total_ext > CMP_W'(SUM_MAX)) begin
      sum_next = SUM_MAX;
    end else begin
      sum_next = total_ext[SUM_W-1:0];
    end
  end

  // Store write and registered prefetch read.
  always_ff @(posedge clk) begin
    if (advance) begin
      counts[win_idx] <= tick_count;
      pf_data         <= counts[pf_addr];
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      window_sum <= sum_next;
      log_slot   <= ctl.slot;
      log_full   <= ctl.log_full;
    end
  end

  // Valid bits, prefetch tag, running total and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      filled        <= '0;
      pf_filled     <= 1'b0;
      pf_idx        <= IDX_ONE;
      running_total <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (advance) begin
        filled[win_idx] <= 1'b1;
        pf_filled       <= filled[pf_addr];
        pf_idx          <= pf_addr;
        running_total   <= total_next;
        out_valid       <= 1'b1;
      end else if (rate_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rate_out.valid      = out_valid;
  assign rate_out.window_sum = window_sum;
  assign rate_out.log_slot   = log_slot;
  assign rate_out.log_full   = log_full;

  // The prefetched entry is the one the held request needs.
  `ASSERT_PROP(a_pf_match, clk, rst, ctl.valid |-> pf_idx == win_idx)
  // A moved request always shows up as a result.
  `ASSERT_PROP(a_out_load, clk, rst, advance |=> out_valid)
  // A written slot is marked valid.
  `ASSERT_PROP(a_fill_mark, clk, rst, advance |=> filled[$past(win_idx)])

endmodule

`default_nettype wire

FILE: rtl/sliding_window_event_rate.sv
// Top level of the sliding-window event rate block.
// Depends on swer_pkg, swer_ifs, swer_tick and swer_window.
`default_nettype none

// Each request carries the keyboard and mouse event totals of one tick and gives
// one result: the events of the last WINDOW_TICKS ticks, the log slot of this
// tick and a flag for the log's last slot. The block takes one request per clock
// unless the output stalls; a request passes the tick stage register and the
// result register. The rate is set by the window stage, which writes one slot of
// the window store and reads the slot needed by the next request in the same
// cycle. The store is cleared at reset at once through per-slot valid bits,
// so no clearing pass is needed. Configuration writes must be made only while
// no request is in flight; a start slot write also loads the log slot pointer.
module sliding_window_event_rate import swer_pkg::*; #(
  parameter int WINDOW_TICKS     = 60,
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  swer_in_if.sink                   tick_in,
  swer_out_if.source                rate_out
);

  localparam int IDX_W = $clog2(WINDOW_TICKS);

  stage_ctl_t                  ctl;
  logic [TICK_COUNT_WIDTH-1:0] tick_count;
  logic [IDX_W-1:0]            win_idx;
  logic                        advance;

  // Delta, window index and slot pointer.
  swer_tick #(
    .WINDOW_TICKS     (WINDOW_TICKS),
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_tick (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .tick_in    (tick_in),
    .advance    (advance),
    .ctl        (ctl),
    .tick_count (tick_count),
    .win_idx    (win_idx)
  );

  // Window store, running total and result register.
  swer_window #(
    .WINDOW_TICKS     (WINDOW_TICKS),
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .tick_count (tick_count),
    .win_idx    (win_idx),
    .advance    (advance),
    .rate_out   (rate_out)
  );

endmodule

`default_nettype wire
